@@ hw/rtl/prqs_pkg.sv @@
// Package: types, codes and sizes shared by the ready-queue scheduler files.
package prqs_pkg;
   localparam int PRIORITY_LEVELS = 8;
   localparam int TASK_SLOTS      = 64;
   localparam int LVL_W           = $clog2(PRIORITY_LEVELS);
   localparam int SLOT_W          = $clog2(TASK_SLOTS);
   localparam int LINK_W          = $clog2(TASK_SLOTS + 1);
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(TASK_SLOTS);
   localparam logic [15:0] ID_MAX = 16'hFFFF;
   localparam logic [15:0] LAST_ID_RESET = 16'd50;
   localparam logic [15:0] FLOOR_RESET   = 16'd300;

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_SCHED   = 2'd1;
   localparam logic [1:0] OP_SET     = 2'd2;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   localparam logic [1:0] ST_READY   = 2'd0;
   localparam logic [1:0] ST_RUNNING = 2'd1;
   localparam logic [1:0] ST_KILLED  = 2'd2;
   localparam logic [1:0] ST_BLOCKED = 2'd3;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NO_ID     = 3'd1;
   localparam logic [2:0] STAT_NONE      = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

   localparam logic [1:0] CSR_FLOOR  = 2'd0;
   localparam logic [1:0] CSR_IDLE   = 2'd1;
   localparam logic [1:0] CSR_SERVER = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] task_id;
      logic [2:0]  priority_req;
      logic [1:0]  task_state;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] result_id;
      logic [1:0]  result_state;
      logic        levels_empty;
   } rsp_type;
endpackage

@@ hw/rtl/priority_ready_queue_scheduler.sv @@
// Top level: multilevel priority FIFO scheduler over a slot memory.
// One command is taken when start is high and busy is low; the result follows
// as a one-cycle rsp_valid strobe in the same cycle that busy drops, and the
// receiver cannot stall it. Add with an explicit id writes the slot and, if
// its level is not empty, links it behind the old tail; schedule and set-state
// visit the levels from the highest down and walk the slots in each FIFO.
// Add with a zero id first runs the id search over the slot memory, with one
// full pass of all slots for each id that turns out taken.
module priority_ready_queue_scheduler (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  prqs_pkg::req_type     req,
   output logic                  rsp_valid,
   output prqs_pkg::rsp_type     rsp,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_write_data
);
   import prqs_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_SRD = 4'd1, S_SCMP = 4'd2, S_APPEND = 4'd3,
                          S_APP2 = 4'd4, S_SCH_HEAD = 4'd5, S_SCH_CHK = 4'd6,
                          S_FND_HEAD = 4'd7, S_FND_CHK = 4'd8, S_FINISH = 4'd9;

   logic [15:0] id_mem [TASK_SLOTS];
   logic [1:0]  st_mem [TASK_SLOTS];
   logic [LINK_W-1:0] lk_mem [TASK_SLOTS];

   logic [3:0] state_ff, state_in;
   logic [15:0] tid_ff, tid_in;
   logic [LVL_W-1:0] prio_ff, prio_in, lvl_ff, lvl_in;
   logic [1:0] st_ff, st_in;
   logic [SLOT_W-1:0] slot_ff, slot_in, idx_ff, idx_in;
   logic [LINK_W-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [16:0] cand_ff, cand_in;
   logic dirty_ff, dirty_in;
   logic [2:0] status_ff, status_in;
   logic [15:0] rid_ff, rid_in;
   logic [1:0] rst_ff, rst_in;
   logic [LINK_W-1:0] head_ff [PRIORITY_LEVELS], head_in [PRIORITY_LEVELS];
   logic [LINK_W-1:0] tail_ff [PRIORITY_LEVELS], tail_in [PRIORITY_LEVELS];
   logic [TASK_SLOTS-1:0] used_ff, used_in;
   logic [15:0] last_ff, last_in;
   logic [15:0] floor_ff;
   logic [2:0] idle_ff, server_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic [15:0] rd_id_ff;
   logic [1:0] rd_st_ff;
   logic [LINK_W-1:0] rd_lk_ff;
   logic [SLOT_W-1:0] rd_addr, wr_addr;
   logic id_we, st_we, lk_we;
   logic [15:0] wr_id;
   logic [1:0] wr_st;
   logic [LINK_W-1:0] wr_lk;

   logic free_ok;
   logic [SLOT_W-1:0] free_idx;
   logic levels_empty;
   logic match;
   logic [16:0] cand_n;
   logic [15:0] floor_eff;

   always_comb begin
      free_ok = 1'b0;
      free_idx = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_ok = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      levels_empty = 1'b1;
      for (int p = 0; p < PRIORITY_LEVELS; p++) begin
         if (p > int'(idle_ff) && p < PRIORITY_LEVELS - int'(server_ff) &&
             head_ff[p] != NULL_LINK) begin
            levels_empty = 1'b0;
         end
      end
   end

   assign floor_eff = (floor_ff == 16'd0) ? 16'd1 : floor_ff;

   always_comb begin
      state_in = state_ff;
      tid_in = tid_ff;
      prio_in = prio_ff;
      lvl_in = lvl_ff;
      st_in = st_ff;
      slot_in = slot_ff;
      idx_in = idx_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      cand_in = cand_ff;
      dirty_in = dirty_ff;
      status_in = status_ff;
      rid_in = rid_ff;
      rst_in = rst_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      used_in = used_ff;
      last_in = last_ff;
      rsp_valid_in = 1'b0;
      rd_addr = '0;
      wr_addr = '0;
      id_we = 1'b0;
      st_we = 1'b0;
      lk_we = 1'b0;
      wr_id = tid_ff;
      wr_st = st_ff;
      wr_lk = NULL_LINK;
      match = 1'b0;
      cand_n = cand_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               tid_in = req.task_id;
               st_in = req.task_state;
               prio_in = (32'(req.priority_req) >= PRIORITY_LEVELS) ?
                         LVL_W'(PRIORITY_LEVELS - 1) : LVL_W'(req.priority_req);
               lvl_in = LVL_W'(PRIORITY_LEVELS - 1);
               status_in = STAT_OK;
               rid_in = '0;
               rst_in = '0;
               unique case (req.operation)
                  OP_ADD: begin
                     if (!free_ok) begin
                        status_in = STAT_FULL;
                        state_in = S_FINISH;
                     end else begin
                        slot_in = free_idx;
                        if (req.task_id == 16'd0) begin
                           cand_in = (last_ff == ID_MAX) ? {1'b0, floor_eff} :
                                     {1'b0, last_ff} + 17'd1;
                           idx_in = '0;
                           dirty_in = 1'b0;
                           state_in = S_SRD;
                        end else begin
                           state_in = S_APPEND;
                        end
                     end
                  end
                  OP_SCHED: state_in = S_SCH_HEAD;
                  OP_SET:   state_in = S_FND_HEAD;
                  default:  state_in = S_FINISH;
               endcase
            end
         end
         S_SRD: begin
            rd_addr = idx_ff;
            state_in = S_SCMP;
         end
         S_SCMP: begin
            match = used_ff[idx_ff] && (rd_id_ff == cand_ff[15:0]);
            cand_n = match ? cand_ff + 17'd1 : cand_ff;
            cand_in = cand_n;
            if (cand_n[16]) begin
               status_in = STAT_NO_ID;
               state_in = S_FINISH;
            end else if (32'(idx_ff) == TASK_SLOTS - 1) begin
               idx_in = '0;
               if (dirty_ff || match) begin
                  dirty_in = 1'b0;
                  state_in = S_SRD;
               end else begin
                  last_in = cand_ff[15:0];
                  tid_in = cand_ff[15:0];
                  state_in = S_APPEND;
               end
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
               dirty_in = dirty_ff || match;
               state_in = S_SRD;
            end
         end
         S_APPEND: begin
            wr_addr = slot_ff;
            id_we = 1'b1;
            st_we = 1'b1;
            lk_we = 1'b1;
            wr_st = (st_ff == ST_RUNNING) ? ST_READY : st_ff;
            used_in[slot_ff] = 1'b1;
            rid_in = tid_ff;
            rst_in = wr_st;
            if (tail_ff[prio_ff] == NULL_LINK) begin
               head_in[prio_ff] = {1'b0, slot_ff};
               tail_in[prio_ff] = {1'b0, slot_ff};
               state_in = S_FINISH;
            end else begin
               state_in = S_APP2;
            end
         end
         S_APP2: begin
            wr_addr = tail_ff[prio_ff][SLOT_W-1:0];
            lk_we = 1'b1;
            wr_lk = {1'b0, slot_ff};
            tail_in[prio_ff] = {1'b0, slot_ff};
            state_in = S_FINISH;
         end
         S_SCH_HEAD, S_FND_HEAD: begin
            if (head_ff[lvl_ff] == NULL_LINK) begin
               if (lvl_ff == '0) begin
                  status_in = (state_ff == S_SCH_HEAD) ? STAT_NONE : STAT_NOT_FOUND;
                  state_in = S_FINISH;
               end else begin
                  lvl_in = lvl_ff - LVL_W'(1);
               end
            end else begin
               rd_addr = head_ff[lvl_ff][SLOT_W-1:0];
               cur_in = head_ff[lvl_ff];
               prev_in = NULL_LINK;
               state_in = (state_ff == S_SCH_HEAD) ? S_SCH_CHK : S_FND_CHK;
            end
         end
         S_SCH_CHK, S_FND_CHK: begin
            if (state_ff == S_SCH_CHK) begin
               match = (rd_st_ff == ST_READY) || (rd_st_ff == ST_KILLED);
            end else begin
               match = (rd_id_ff == tid_ff);
            end
            if (match && state_ff == S_SCH_CHK) begin
               if (prev_ff == NULL_LINK) begin
                  head_in[lvl_ff] = rd_lk_ff;
               end else begin
                  wr_addr = prev_ff[SLOT_W-1:0];
                  lk_we = 1'b1;
                  wr_lk = rd_lk_ff;
               end
               if (tail_ff[lvl_ff] == cur_ff) begin
                  tail_in[lvl_ff] = prev_ff;
               end
               used_in[cur_ff[SLOT_W-1:0]] = 1'b0;
               rid_in = rd_id_ff;
               rst_in = rd_st_ff;
               state_in = S_FINISH;
            end else if (match) begin
               wr_addr = cur_ff[SLOT_W-1:0];
               st_we = 1'b1;
               wr_st = st_ff;
               rid_in = tid_ff;
               rst_in = st_ff;
               state_in = S_FINISH;
            end else begin
               prev_in = cur_ff;
               if (rd_lk_ff == NULL_LINK) begin
                  if (lvl_ff == '0) begin
                     status_in = (state_ff == S_SCH_CHK) ? STAT_NONE : STAT_NOT_FOUND;
                     state_in = S_FINISH;
                  end else begin
                     lvl_in = lvl_ff - LVL_W'(1);
                     state_in = (state_ff == S_SCH_CHK) ? S_SCH_HEAD : S_FND_HEAD;
                  end
               end else begin
                  cur_in = rd_lk_ff;
                  rd_addr = rd_lk_ff[SLOT_W-1:0];
               end
            end
         end
         S_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (id_we) id_mem[wr_addr] <= wr_id;
      if (st_we) st_mem[wr_addr] <= wr_st;
      if (lk_we) lk_mem[wr_addr] <= wr_lk;
      rd_id_ff <= id_mem[rd_addr];
      rd_st_ff <= st_mem[rd_addr];
      rd_lk_ff <= lk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      tid_ff <= tid_in;
      prio_ff <= prio_in;
      lvl_ff <= lvl_in;
      st_ff <= st_in;
      slot_ff <= slot_in;
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      cand_ff <= cand_in;
      dirty_ff <= dirty_in;
      status_ff <= status_in;
      rid_ff <= rid_in;
      rst_ff <= rst_in;
      if (state_ff == S_FINISH) begin
         rsp_ff.status <= status_ff;
         rsp_ff.result_id <= rid_ff;
         rsp_ff.result_state <= rst_ff;
         rsp_ff.levels_empty <= levels_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         last_ff <= LAST_ID_RESET;
         rsp_valid_ff <= 1'b0;
         floor_ff <= FLOOR_RESET;
         idle_ff <= 3'd0;
         server_ff <= 3'd1;
         for (int p = 0; p < PRIORITY_LEVELS; p++) begin
            head_ff[p] <= NULL_LINK;
            tail_ff[p] <= NULL_LINK;
         end
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FLOOR:  floor_ff <= csr_write_data;
               CSR_IDLE:   idle_ff <= csr_write_data[2:0];
               CSR_SERVER: server_ff <= csr_write_data[2:0];
               default: ;
            endcase
         end
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
endmodule

@@ hw/rtl/prqs_checker.sv @@
// Port-level checker for the ready-queue scheduler, bound to the top level.
module prqs_assertions (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input prqs_pkg::rsp_type rsp
);
   import prqs_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted command did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without a command");

   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.status <= STAT_NOT_FOUND) else $error("bad status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == STAT_NONE || rsp.status == STAT_FULL ||
      rsp.status == STAT_NO_ID) |-> rsp.result_id == 16'd0)
      else $error("failed command returned an id");
endmodule

bind priority_ready_queue_scheduler prqs_assertions u_prqs_assertions (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp(rsp)
);
